// ----- rtl/rbb_pkg.sv -----
// Package: shared constants and types for the RAW12 Bayer binning unit.
`timescale 1ns / 1ps
`default_nettype none
package rbb_pkg;

    localparam int DEF_MAX_GROUPS = 2048;
    localparam int GROUP_W        = 24;
    localparam int SAMPLE_W       = 12;
    localparam int PIX_W          = 16;
    localparam int GPR_W          = 12;
    localparam int PAIRS_W        = 13;
    localparam int PAIR_W         = 12;
    localparam int LASTC_W        = 14;
    localparam int CFG_DATA_W     = 13;
    localparam int OUT_DATA_W     = 3 * PIX_W;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = PTR_W + 1;

    localparam logic [PAIRS_W-1:0] PAIR_LIMIT = PAIRS_W'(4096);

    typedef enum logic [0:0] {
        CFG_GROUPS_PER_ROW = 1'b0,
        CFG_ROW_PAIRS      = 1'b1
    } cfg_idx_t;

    // Odd-row item handed from the front end to the back end
    typedef struct packed {
        logic               valid;
        logic [GROUP_W-1:0] grp;
        logic               row_end;
        logic               frame_end;
    } stage_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
        logic             frame_end;
    } pix_t;

    function automatic logic [SAMPLE_W-1:0] sample_low(input logic [GROUP_W-1:0] g);
        sample_low = {g[7:0], g[19:16]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_high(input logic [GROUP_W-1:0] g);
        sample_high = {g[15:8], g[23:20]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rbb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rbb_front.sv -----
// Front end: config registers, row/column tracking, line store access.
`timescale 1ns / 1ps
`default_nettype none
module rbb_front #(
    parameter int MAX_GROUPS = rbb_pkg::DEF_MAX_GROUPS,
    parameter int COL_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rbb_pkg::GROUP_W-1:0]     s_tdata,
    input  wire logic [rbb_pkg::CNT_W-1:0]       fifo_count,
    output logic                                 ram_we,
    output logic                                 ram_re,
    output logic      [COL_W-1:0]                ram_addr,
    output rbb_pkg::stage_t                      stage
);
    import rbb_pkg::*;

    localparam logic [LASTC_W-1:0] MAX_G = LASTC_W'(MAX_GROUPS);

    logic [GPR_W-1:0]   gpr_reg;
    logic [PAIRS_W-1:0] pairs_reg;
    logic               odd_reg;
    logic [COL_W-1:0]   col_reg;
    logic [PAIR_W-1:0]  pair_reg;
    stage_t             stage_reg;
    stage_t             stage_next;

    logic [LASTC_W-1:0] g_eff;
    logic [LASTC_W-1:0] g_clamp;
    logic [LASTC_W-1:0] last_col;
    logic [PAIRS_W-1:0] p_eff;
    logic [PAIRS_W-1:0] p_clamp;
    logic [PAIR_W-1:0]  last_pair;
    logic               at_row_end;
    logic               at_frame_end;
    logic               accept;
    logic [CNT_W:0]     in_flight;

    always_comb
    begin
        g_eff    = (gpr_reg == '0) ? LASTC_W'(1) : LASTC_W'(gpr_reg);
        g_clamp  = (g_eff > MAX_G) ? MAX_G : g_eff;
        last_col = g_clamp - LASTC_W'(1);
        p_eff    = (pairs_reg == '0) ? PAIRS_W'(1) : pairs_reg;
        p_clamp  = (p_eff > PAIR_LIMIT) ? PAIR_LIMIT : p_eff;
        last_pair = PAIR_W'(p_clamp - PAIRS_W'(1));
    end

    assign at_row_end   = LASTC_W'(col_reg) >= last_col;
    assign at_frame_end = at_row_end && (pair_reg >= last_pair);

    // Credit: queue entries plus the item in the read stage
    assign in_flight = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(stage_reg.valid);
    assign s_tready  = in_flight < (CNT_W + 1)'(FIFO_DEPTH);
    assign accept    = s_tvalid && s_tready;

    assign ram_we   = accept && !odd_reg;
    assign ram_re   = accept && odd_reg;
    assign ram_addr = col_reg;
    assign stage    = stage_reg;

    always_comb
    begin
        stage_next.valid     = accept && odd_reg;
        stage_next.grp       = s_tdata;
        stage_next.row_end   = at_row_end;
        stage_next.frame_end = at_frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_reg   <= GPR_W'(1);
            pairs_reg <= PAIRS_W'(1);
            odd_reg   <= 1'b0;
            col_reg   <= '0;
            pair_reg  <= '0;
            stage_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GROUPS_PER_ROW: gpr_reg   <= cfg_wdata[GPR_W-1:0];
                    CFG_ROW_PAIRS:      pairs_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
            stage_reg.valid <= stage_next.valid;
            if (accept)
            begin
                stage_reg.grp       <= stage_next.grp;
                stage_reg.row_end   <= stage_next.row_end;
                stage_reg.frame_end <= stage_next.frame_end;
                if (at_row_end)
                begin
                    col_reg <= '0;
                    odd_reg <= !odd_reg;
                    if (odd_reg)
                    begin
                        pair_reg <= at_frame_end ? '0 : pair_reg + PAIR_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rbb_back.sv -----
// Back end: bins stored and current groups into RGB, output queue.
`timescale 1ns / 1ps
`default_nettype none
module rbb_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rbb_pkg::stage_t               stage,
    input  wire logic [rbb_pkg::GROUP_W-1:0]   stored,
    output logic      [rbb_pkg::CNT_W-1:0]     fifo_count,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [rbb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import rbb_pkg::*;

    pix_t             pix;
    pix_t             fifo_mem [FIFO_DEPTH];
    pix_t             head;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    always_comb
    begin
        pix.red       = {sample_high(stored), 4'b0000};
        pix.green     = {1'b0, sample_low(stored), 3'b000}
                      + {1'b0, sample_high(stage.grp), 3'b000};
        pix.blue      = {sample_low(stage.grp), 4'b0000};
        pix.row_end   = stage.row_end;
        pix.frame_end = stage.frame_end;
    end

    assign push = stage.valid;
    assign pop  = m_tvalid && m_tready;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= pix;
        end
    end

    assign head       = fifo_mem[rd_ptr_reg];
    assign fifo_count = count_reg;
    assign m_tvalid   = count_reg != '0;
    assign m_tdata    = {head.blue, head.green, head.red};
    assign m_tlast    = head.row_end;
    assign m_tuser    = head.frame_end;

endmodule
`default_nettype wire

// ----- rtl/raw12_bayer_bin_to_rgb_unit.sv -----
// Top level: RAW12 GRBG Bayer 2x2 binning to RGB.
//
//  port group   dir  payload
//  s_*          in   tdata[23:0] = packed_group
//  m_*          out  tdata = red[15:0], green[31:16], blue[47:32];
//                    tlast = row_end; tuser = frame_end
//  cfg_*        in   index 0 groups_per_row, index 1 row_pairs
//
//  One item per cycle sustained. An odd-row item reads the line store at
//  accept; the read data and the item are registered in the read stage,
//  then its pixel is written into the 4-entry output queue and can leave
//  from there. Reset clears position and config (both registers to 1); the
//  line store is not cleared. Input stalls only when the output queue plus the read stage hold four items.
`timescale 1ns / 1ps
`default_nettype none
module raw12_bayer_bin_to_rgb_unit #(
    parameter int MAX_GROUPS = rbb_pkg::DEF_MAX_GROUPS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rbb_pkg::GROUP_W-1:0]      s_tdata,  // packed_group
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [rbb_pkg::OUT_DATA_W-1:0]   m_tdata,  // red, green, blue
    output logic                                  m_tlast,
    output logic                                  m_tuser   // frame_end
);
    import rbb_pkg::*;

    localparam int COL_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic               ram_we;
    logic               ram_re;
    logic [COL_W-1:0]   ram_addr;
    logic [GROUP_W-1:0] ram_rdata;
    logic [CNT_W-1:0]   fifo_count;
    stage_t             stage;

    rbb_front #(
        .MAX_GROUPS (MAX_GROUPS),
        .COL_W      (COL_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .fifo_count (fifo_count),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .stage      (stage)
    );

    rbb_ram #(
        .WIDTH (GROUP_W),
        .DEPTH (MAX_GROUPS),
        .AW    (COL_W)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    rbb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .stored     (ram_rdata),
        .fifo_count (fifo_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

// ----- verif/raw12_bayer_bin_to_rgb_unit_tb.sv -----
// Testbench for the RAW12 Bayer binning unit: directed and random streams vs. a predictor.
`timescale 1ns / 1ps
module raw12_bayer_bin_to_rgb_unit_tb;
    import rbb_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_GROUPS;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_index = CFG_GROUPS_PER_ROW;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [GROUP_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // binning predictor state
    logic [GPR_W-1:0]   row_groups_reg  = GPR_W'(1);
    logic [PAIRS_W-1:0] frame_pairs_reg = PAIRS_W'(1);
    logic [GROUP_W-1:0] line_copy [STORE_DEPTH];
    logic               on_odd_row = 1'b0;
    int                 col_pos    = 0;
    int                 pair_pos   = 0;
    pix_t               pending_pixels [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatches     = 0;

    raw12_bayer_bin_to_rgb_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int last_col();
        int g;
        g = row_groups_reg;
        if (g == 0)
            g = 1;
        if (g > STORE_DEPTH)
            g = STORE_DEPTH;
        return g - 1;
    endfunction

    function automatic int last_pair();
        int p;
        p = frame_pairs_reg;
        if (p == 0)
            p = 1;
        if (p > int'(PAIR_LIMIT))
            p = int'(PAIR_LIMIT);
        return p - 1;
    endfunction

    // even row (G,R) is stored; odd row (B,G) pairs with the stored group
    function automatic void bin_group(input logic [GROUP_W-1:0] grp);
        logic [GROUP_W-1:0]  upper;
        logic [SAMPLE_W-1:0] g_top;
        logic [SAMPLE_W-1:0] r_smp;
        logic [SAMPLE_W-1:0] b_smp;
        logic [SAMPLE_W-1:0] g_bot;
        logic                row_done;
        pix_t                px;
        row_done = col_pos >= last_col();
        if (!on_odd_row)
        begin
            line_copy[col_pos] = grp;
            if (row_done)
            begin
                col_pos    = 0;
                on_odd_row = 1'b1;
            end
            else
                col_pos++;
            return;
        end
        upper        = line_copy[col_pos];
        g_top        = {upper[7:0], upper[19:16]};
        r_smp        = {upper[15:8], upper[23:20]};
        b_smp        = {grp[7:0], grp[19:16]};
        g_bot        = {grp[15:8], grp[23:20]};
        px.red       = {r_smp, 4'h0};
        px.green     = {1'b0, g_top, 3'b000} + {1'b0, g_bot, 3'b000};
        px.blue      = {b_smp, 4'h0};
        px.row_end   = row_done;
        px.frame_end = row_done && (pair_pos >= last_pair());
        pending_pixels.push_back(px);
        if (row_done)
        begin
            col_pos    = 0;
            on_odd_row = 1'b0;
            pair_pos   = px.frame_end ? 0 : pair_pos + 1;
        end
        else
            col_pos++;
    endfunction

    task automatic send_group(input logic [GROUP_W-1:0] grp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= grp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bin_group(grp);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_group(GROUP_W'($urandom));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_GROUPS_PER_ROW)
            row_groups_reg = GPR_W'(value);
        else
            frame_pairs_reg = PAIRS_W'(value);
    endtask

    // even-row items give no pixel, so allow extra cycles after the last one
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // end an open odd row so a longer row never reads columns not stored yet
    task automatic close_odd_row();
        if (on_odd_row)
        begin
            write_reg(CFG_GROUPS_PER_ROW, 1);
            send_group(GROUP_W'($urandom));
            settle();
        end
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    task automatic test_reset_geometry();
        set_idling(0);
        send_group(24'h000000);
        send_group(24'hFFFFFF);
        send_group(24'hFFFFFF);
        send_group(24'h000000);
        settle();
    endtask

    // zero row length and zero frame height both act as one
    task automatic test_zero_sizes();
        write_reg(CFG_GROUPS_PER_ROW, 0);
        write_reg(CFG_ROW_PAIRS, 0);
        send_group(24'h0F0F0F);
        send_group(24'hF0F0F0);
        settle();
    endtask

    // shrinking row length mid-row and frame height mid-frame ends them at once
    task automatic test_midstream_resize();
        write_reg(CFG_GROUPS_PER_ROW, 5);
        write_reg(CFG_ROW_PAIRS, 8191);
        send_random(7);
        settle();
        write_reg(CFG_GROUPS_PER_ROW, 3);
        send_random(7);
        settle();
        write_reg(CFG_ROW_PAIRS, 2);
        write_reg(CFG_GROUPS_PER_ROW, 1);
        send_group(24'h5A3CC3);
        send_group(24'hA5C33C);
        settle();
    endtask

    // oversize row length, then a shrink below the current column mid-row
    task automatic test_oversize_row();
        write_reg(CFG_GROUPS_PER_ROW, 4095);
        write_reg(CFG_ROW_PAIRS, 1);
        send_random(40);
        settle();
        write_reg(CFG_GROUPS_PER_ROW, 20);
        send_random(21);
        settle();
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_GROUPS_PER_ROW, 4);
        write_reg(CFG_ROW_PAIRS, 2);
        hold_asked++;
        send_random(24);
        settle();
    endtask

    task automatic test_random_stream();
        int pick;
        for (int chunk = 0; chunk < 8; chunk++)
        begin
            set_idling(chunk % 4);
            close_odd_row();
            pick = $urandom_range(15);
            case (pick)
                0: write_reg(CFG_GROUPS_PER_ROW, 0);
                1: write_reg(CFG_GROUPS_PER_ROW, $urandom_range(4095, 2048));
                2: write_reg(CFG_GROUPS_PER_ROW, $urandom_range(40, 9));
                default: write_reg(CFG_GROUPS_PER_ROW, $urandom_range(8, 1));
            endcase
            pick = $urandom_range(15);
            case (pick)
                0: write_reg(CFG_ROW_PAIRS, 0);
                1: write_reg(CFG_ROW_PAIRS, $urandom_range(8191, 4096));
                2: write_reg(CFG_ROW_PAIRS, $urandom_range(64, 5));
                default: write_reg(CFG_ROW_PAIRS, $urandom_range(4, 1));
            endcase
            send_random(110);
            settle();
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        pix_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pixel: r=%h g=%h b=%h row_end=%b frame_end=%b",
                             m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast, m_tuser);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[15:0] !== want.red || m_tdata[31:16] !== want.green ||
                    m_tdata[47:32] !== want.blue || m_tlast !== want.row_end ||
                    m_tuser !== want.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("pixel mismatch: exp r=%h g=%h b=%h re=%b fe=%b,",
                               want.red, want.green, want.blue, want.row_end,
                               want.frame_end);
                        $display(" got r=%h g=%h b=%h re=%b fe=%b",
                                 m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                 m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_zero_sizes();
        test_midstream_resize();
        test_oversize_row();
        test_output_backpressure();
        test_random_stream();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
